// ===== rtl/fip_pkg.sv =====
// Free index pool shared definitions: widths, command and status codes,
// reset constants and the control bundle broadcast to the cell row.
// No dependencies.
`timescale 1ns / 1ps

package fip_pkg;

    localparam int IDX_W           = 8;
    localparam int SIZE_W          = 9;
    localparam int CMD_W           = 2;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_DEFAULT   = 256;
    localparam int POOL_SIZE_RESET = 256;

    localparam logic [CMD_W-1:0] CMD_POP    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic del;
    } fip_ctrl_t;

endpackage

// ===== rtl/fip_cell.sv =====
// One stack cell of the free index pool: holds one entry and its valid bit.
// Shifts toward the bottom on push, toward the top on pop or delete closure.
// Depends on fip_pkg.
`timescale 1ns / 1ps

module fip_cell #(
    parameter int CELL_ID = 0,
    parameter int CNT_W   = 9,
    parameter int RESET_N = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fip_pkg::fip_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]            load_n,
    input  logic [fip_pkg::IDX_W-1:0]   item,
    input  logic [fip_pkg::IDX_W-1:0]   upper_value,
    input  logic                        upper_valid,
    input  logic [fip_pkg::IDX_W-1:0]   lower_value,
    input  logic                        lower_valid,
    input  logic                        found_in,
    output logic                        found_out,
    output logic [fip_pkg::IDX_W-1:0]   value,
    output logic                        valid
);
    import fip_pkg::*;

    localparam logic [IDX_W-1:0] LOAD_VAL    = IDX_W'(CELL_ID % 256);
    localparam logic             RESET_VALID = (CELL_ID < RESET_N);

    logic [IDX_W-1:0] value_reg;
    logic [IDX_W-1:0] value_next;
    logic             valid_reg;
    logic             valid_next;
    logic             match;

    assign match     = ctrl.del && valid_reg && (value_reg == item);
    assign found_out = found_in || match;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            value_next = LOAD_VAL;
            valid_next = (CNT_W'(CELL_ID) < load_n);
        end
        else if (ctrl.push)
        begin
            value_next = upper_value;
            valid_next = upper_valid;
        end
        else if (ctrl.pop || (ctrl.del && found_out))
        begin
            value_next = lower_value;
            valid_next = lower_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= LOAD_VAL;
            valid_reg <= RESET_VALID;
        end
        else
        begin
            value_reg <= value_next;
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/free_index_pool_unit.sv =====
// Free index pool top level: command decode, entry count, result beat
// registers and the row of fip_cell stack cells. Depends on fip_pkg, fip_cell.
// The result beat is registered and appears in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, every op is one cell shift.
// Reset loads 0..min(256,DEPTH)-1 with 0 on top; a pool_size write reloads
// the row. The receiver cannot stall; done is a one-cycle strobe.
`timescale 1ns / 1ps

module free_index_pool_unit #(
    parameter int DEPTH = fip_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fip_pkg::CMD_W-1:0]      cmd,
    input  logic [fip_pkg::IDX_W-1:0]      item_index,
    output logic                           done,
    output logic [fip_pkg::IDX_W-1:0]      out_index,
    output logic [fip_pkg::STATUS_W-1:0]   status,
    output logic [fip_pkg::SIZE_W-1:0]     free_count,
    input  logic                           pool_size_we,
    input  logic [fip_pkg::SIZE_W-1:0]     pool_size
);
    import fip_pkg::*;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LW      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
    localparam int RESET_N = (POOL_SIZE_RESET > DEPTH) ? DEPTH : POOL_SIZE_RESET;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(RESET_N);
    localparam logic [CNT_W-1:0] COUNT_FULL  = CNT_W'(DEPTH);
    localparam logic [LW-1:0]    DEPTH_L     = LW'(DEPTH);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                done_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic [IDX_W-1:0]    out_index_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                accept;
    logic                empty;
    logic                full;
    logic                hit;
    logic [LW-1:0]       size_l;
    logic [CNT_W-1:0]    load_n;
    fip_ctrl_t           ctrl;

    logic [IDX_W-1:0]    cell_value [DEPTH];
    logic                cell_valid [DEPTH];
    logic [DEPTH:0]      found;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign empty  = (count_reg == '0);
    assign full   = (count_reg >= COUNT_FULL);
    assign size_l = LW'(pool_size);
    assign load_n = (size_l > DEPTH_L) ? COUNT_FULL : CNT_W'(size_l);
    assign hit    = found[DEPTH];

    always_comb
    begin
        ctrl.load = pool_size_we;
        ctrl.push = !pool_size_we && accept && (cmd == CMD_PUSH) && !full;
        ctrl.pop  = !pool_size_we && accept && (cmd == CMD_POP) && !empty;
        ctrl.del  = !pool_size_we && accept && (cmd == CMD_DELETE);
    end

    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [IDX_W-1:0] up_value;
        logic             up_valid;
        logic [IDX_W-1:0] dn_value;
        logic             dn_valid;

        if (i == 0)
        begin : g_top
            assign up_value = item_index;
            assign up_valid = 1'b1;
        end
        else
        begin : g_mid
            assign up_value = cell_value[i-1];
            assign up_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bot
            assign dn_value = '0;
            assign dn_valid = 1'b0;
        end
        else
        begin : g_inner
            assign dn_value = cell_value[i+1];
            assign dn_valid = cell_valid[i+1];
        end

        fip_cell #(
            .CELL_ID (i),
            .CNT_W   (CNT_W),
            .RESET_N (RESET_N)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load_n      (load_n),
            .item        (item_index),
            .upper_value (up_value),
            .upper_valid (up_valid),
            .lower_value (dn_value),
            .lower_valid (dn_valid),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_index_next = '0;
        status_next    = ST_OK;
        if (pool_size_we)
        begin
            count_next = load_n;
        end
        else if (accept)
        begin
            case (cmd)
                CMD_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        out_index_next = cell_value[0];
                    end
                end
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE:
                begin
                    if (hit)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        status_reg    <= status_next;
    end

    logic [CNT_W-1:0] count_shown_reg;
    logic [LW-1:0]    count_wide;

    always_ff @(posedge clk)
    begin
        count_shown_reg <= count_next;
    end

    assign count_wide = LW'(count_shown_reg);
    assign done       = done_reg;
    assign out_index  = out_index_reg;
    assign status     = status_reg;
    assign free_count = count_wide[SIZE_W-1:0];

endmodule

// ===== rtl/fip_checker.sv =====
// Port-level checker for free_index_pool_unit, attached by bind.
// Depends on fip_pkg and the top level's port list.
`timescale 1ns / 1ps

module fip_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [fip_pkg::IDX_W-1:0]      out_index,
    input logic [fip_pkg::STATUS_W-1:0]   status,
    input logic [fip_pkg::SIZE_W-1:0]     free_count
);
    import fip_pkg::*;

    a_beat_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted command produced no result beat");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result beat without an accepted command");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (free_count == '0))
        else $error("pop on empty with nonzero count");

    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (out_index == '0))
        else $error("failed command returned an index");

endmodule

bind free_index_pool_unit fip_checker u_fip_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .out_index  (out_index),
    .status     (status),
    .free_count (free_count)
);
